>>> hw/rtl/rbrf_pkg.sv
// Shared types, register codes and constants for the blended rectangle fill engine.
package rbrf_pkg;

   // Default frame store geometry
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RASTER_MODE    = 2'd0,
      CSR_MERGE_WEIGHT   = 2'd1,
      CSR_SURFACE_WIDTH  = 2'd2,
      CSR_SURFACE_HEIGHT = 2'd3
   } csr_index_type;

   // Raster modes (the register holds three bits, codes above merge mean nothing)
   localparam logic [2:0] ROP_OVERWRITE = 3'd0;
   localparam logic [2:0] ROP_XOR       = 3'd1;
   localparam logic [2:0] ROP_ADD       = 3'd2;
   localparam logic [2:0] ROP_SUB       = 3'd3;
   localparam logic [2:0] ROP_MERGE     = 3'd4;

   // Item operations
   localparam logic OP_FILL = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Register reset values and limits
   localparam logic [4:0] WEIGHT_FULL   = 5'd16;
   localparam logic [8:0] SURFACE_RESET = 9'd240;

   // RGB565 channel limits
   localparam logic [4:0] CHAN5_MAX = 5'd31;
   localparam logic [5:0] CHAN6_MAX = 6'd63;

   typedef struct packed {
      logic               operation;
      logic signed [15:0] left_x;
      logic signed [15:0] top_y;
      logic signed [15:0] right_x;
      logic signed [15:0] bottom_y;
      logic [15:0]        fill_color;
      logic [15:0]        pixel_address;
   } req_type;

   typedef struct packed {
      logic [15:0] read_pixel;
      logic [16:0] pixels_written;
   } rsp_type;

endpackage

>>> hw/rtl/rgb565_blended_rect_fill.sv
// Top level: RGB565 frame store with clipped rectangle fill under raster modes.
//
//  channel   ports                                  direction  beat taken when
//  item      start, busy, req_data                  in         start & !busy
//  result    rsp_valid, rsp_data                    out        rsp_valid (one cycle)
//  config    csr_valid, csr_ready, csr_index/data   in         csr_valid & csr_ready
//
// A read item passes through the clip and read states before its result strobe.
// A fill passes through clip and base, walks the clipped rectangle with one pixel
// read-modify-write per cycle through the frame store's single write port, and
// answers from drain; a rejected fill is answered from clip. After reset the
// store is swept to zero with busy high; configuration writes are taken
// throughout. Results are shown for exactly one cycle and cannot be held off.
module rgb565_blended_rect_fill
   import rbrf_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW  = $clog2(STORE_WORDS);
   localparam int XW  = $clog2(MAX_WIDTH + 1);
   localparam int YW  = $clog2(MAX_HEIGHT + 1);
   localparam int CXW = $clog2(MAX_WIDTH);
   localparam int CYW = $clog2(MAX_HEIGHT);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CLIP,
      ST_BASE,
      ST_FILL,
      ST_DRAIN,
      ST_READ
   } state_type;

   state_type          state_ff;
   req_type            item_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic [CXW-1:0]     cx0_ff, cx1_ff, col_ff;
   logic [CYW-1:0]     cy0_ff, cy1_ff, row_ff;
   logic [AW-1:0]      row_base_ff;
   logic [16:0]        count_ff;
   logic               wr_pend_ff;
   logic [AW-1:0]      wr_addr_ff;
   logic               rd_ok_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [2:0]         raster_mode_ff;
   logic [4:0]         merge_weight_ff;
   logic [8:0]         surface_width_ff;
   logic [8:0]         surface_height_ff;

   logic [XW-1:0]      w_eff;
   logic [YW-1:0]      h_eff;
   logic signed [16:0] w_s, h_s, lx, ty, rx, by;
   logic               reject;
   logic [AW-1:0]      fill_addr;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [15:0]        ram_wdata, ram_rdata, rop_pixel;
   logic               accept;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         raster_mode_ff    <= ROP_OVERWRITE;
         merge_weight_ff   <= WEIGHT_FULL;
         surface_width_ff  <= SURFACE_RESET;
         surface_height_ff <= SURFACE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RASTER_MODE:    raster_mode_ff    <= csr_data[2:0];
            CSR_MERGE_WEIGHT:   merge_weight_ff   <= (csr_data[4:0] > WEIGHT_FULL) ?
                                                     WEIGHT_FULL : csr_data[4:0];
            CSR_SURFACE_WIDTH:  surface_width_ff  <= csr_data;
            CSR_SURFACE_HEIGHT: surface_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Saturate the surface size into the store
   always_comb begin
      priority if (surface_width_ff == '0) begin
         w_eff = XW'(1);
      end else if (32'(surface_width_ff) > MAX_WIDTH) begin
         w_eff = XW'(MAX_WIDTH);
      end else begin
         w_eff = XW'(surface_width_ff);
      end
      priority if (surface_height_ff == '0) begin
         h_eff = YW'(1);
      end else if (32'(surface_height_ff) > MAX_HEIGHT) begin
         h_eff = YW'(MAX_HEIGHT);
      end else begin
         h_eff = YW'(surface_height_ff);
      end
   end

   // Widen corners and size for signed clip compares
   assign w_s = signed'(17'(w_eff));
   assign h_s = signed'(17'(h_eff));
   assign lx  = signed'({item_ff.left_x[15], item_ff.left_x});
   assign ty  = signed'({item_ff.top_y[15], item_ff.top_y});
   assign rx  = signed'({item_ff.right_x[15], item_ff.right_x});
   assign by  = signed'({item_ff.bottom_y[15], item_ff.bottom_y});

   // Drop fills that touch nothing
   assign reject = (raster_mode_ff > ROP_MERGE) ||
                   (rx < 0) || (lx >= w_s) || (by < 0) || (ty >= h_s) ||
                   ((raster_mode_ff == ROP_MERGE) && (merge_weight_ff == '0)) ||
                   (lx > rx) || (ty > by);

   assign accept    = start && !busy;
   assign fill_addr = row_base_ff + AW'(col_ff);

   // Sequencer: clear sweep, clip, walk the rectangle, answer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == AW'(STORE_WORDS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  item_ff  <= req_data;
                  state_ff <= ST_CLIP;
               end
            end
            ST_CLIP: begin
               count_ff <= '0;
               rd_ok_ff <= 32'(item_ff.pixel_address) < STORE_WORDS;
               cx0_ff   <= (lx < 0) ? '0 : lx[CXW-1:0];
               cx1_ff   <= (rx >= w_s) ? CXW'(w_eff - XW'(1)) : rx[CXW-1:0];
               cy0_ff   <= (ty < 0) ? '0 : ty[CYW-1:0];
               cy1_ff   <= (by >= h_s) ? CYW'(h_eff - YW'(1)) : by[CYW-1:0];
               priority if (item_ff.operation == OP_READ) begin
                  state_ff <= ST_READ;
               end else if (reject) begin
                  rsp_ff       <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  state_ff <= ST_BASE;
               end
            end
            ST_BASE: begin
               row_base_ff <= AW'(AW'(cy0_ff) * AW'(w_eff));
               row_ff      <= cy0_ff;
               col_ff      <= cx0_ff;
               state_ff    <= ST_FILL;
            end
            ST_FILL: begin
               wr_pend_ff <= 1'b1;
               wr_addr_ff <= fill_addr;
               count_ff   <= count_ff + 17'd1;
               if (col_ff == cx1_ff) begin
                  col_ff <= cx0_ff;
                  if (row_ff == cy1_ff) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     row_ff      <= row_ff + CYW'(1);
                     row_base_ff <= row_base_ff + AW'(w_eff);
                  end
               end else begin
                  col_ff <= col_ff + CXW'(1);
               end
            end
            ST_DRAIN: begin
               rsp_ff.read_pixel     <= '0;
               rsp_ff.pixels_written <= count_ff;
               rsp_valid_ff          <= 1'b1;
               state_ff              <= ST_IDLE;
            end
            ST_READ: begin
               rsp_ff.read_pixel     <= rd_ok_ff ? ram_rdata : '0;
               rsp_ff.pixels_written <= '0;
               rsp_valid_ff          <= 1'b1;
               state_ff              <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Store ports: sweep or write back, read for a pixel or a read item
   assign ram_we    = (state_ff == ST_CLEAR) || wr_pend_ff;
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : wr_addr_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : rop_pixel;
   assign ram_raddr = (state_ff == ST_CLIP) ? AW'(item_ff.pixel_address) : fill_addr;

   rbrf_ram #(
      .WIDTH (16),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rbrf_rop u_rop (
      .mode      (raster_mode_ff),
      .weight    (merge_weight_ff),
      .pixel_in  (ram_rdata),
      .color     (item_ff.fill_color),
      .pixel_out (rop_pixel)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   assert property (@(posedge clock) disable iff (reset) accept |=> (state_ff == ST_CLIP))
      else $error("accepted item did not enter clipping");

   assert property (@(posedge clock) disable iff (reset)
                    wr_pend_ff |-> (state_ff == ST_FILL || state_ff == ST_DRAIN))
      else $error("pixel write back outside a fill");

   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_CLEAR) |-> (!rsp_valid_ff && !wr_pend_ff))
      else $error("activity during clearing sweep");

endmodule

>>> hw/rtl/rbrf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module rbrf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one word, read one word a cycle
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/rbrf_rop.sv
// Raster operation unit: combines a stored RGB565 pixel with the fill colour.
module rbrf_rop
   import rbrf_pkg::*;
(
   input  logic [2:0]  mode,
   input  logic [4:0]  weight,
   input  logic [15:0] pixel_in,
   input  logic [15:0] color,
   output logic [15:0] pixel_out
);

   logic [4:0] pb, pr, cb, cr;
   logic [5:0] pg, cg;
   logic [4:0] wc;
   logic [5:0] add_b, add_r;
   logic [6:0] add_g;
   logic [9:0] mix_b, mix_g, mix_r;
   logic [4:0] nb, nr;
   logic [5:0] ng;

   // Split both words into channels
   assign pb = pixel_in[4:0];
   assign pg = pixel_in[10:5];
   assign pr = pixel_in[15:11];
   assign cb = color[4:0];
   assign cg = color[10:5];
   assign cr = color[15:11];

   // Per-channel sums and weighted blend
   assign wc    = WEIGHT_FULL - weight;
   assign add_b = {1'b0, pb} + {1'b0, cb};
   assign add_g = {1'b0, pg} + {1'b0, cg};
   assign add_r = {1'b0, pr} + {1'b0, cr};
   assign mix_b = 10'(cb) * 10'(weight) + 10'(pb) * 10'(wc);
   assign mix_g = 10'(cg) * 10'(weight) + 10'(pg) * 10'(wc);
   assign mix_r = 10'(cr) * 10'(weight) + 10'(pr) * 10'(wc);

   // Pick the result of the active mode
   always_comb begin
      nb        = '0;
      ng        = '0;
      nr        = '0;
      pixel_out = color;
      unique case (mode)
         ROP_OVERWRITE: begin
            pixel_out = color;
         end
         ROP_XOR: begin
            pixel_out = pixel_in ^ color;
         end
         ROP_ADD: begin
            nb        = add_b[5] ? CHAN5_MAX : add_b[4:0];
            ng        = add_g[6] ? CHAN6_MAX : add_g[5:0];
            nr        = add_r[5] ? CHAN5_MAX : add_r[4:0];
            pixel_out = {nr, ng, nb};
         end
         ROP_SUB: begin
            nb        = (pb > cb) ? pb - cb : '0;
            ng        = (pg > cg) ? pg - cg : '0;
            nr        = (pr > cr) ? pr - cr : '0;
            pixel_out = {nr, ng, nb};
         end
         default: begin
            nb        = mix_b[8:4];
            ng        = mix_g[9:4];
            nr        = mix_r[8:4];
            pixel_out = {nr, ng, nb};
         end
      endcase
   end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the RGB565 blended rectangle fill engine.
module testbench;
   import rbrf_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int TIMEOUT_CYCLES  = 4_000_000;
   localparam int STORE_WORDS     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 12;
   localparam int TAIL_CYCLES     = 16;

   // Raster codes the register can hold but that draw nothing
   localparam logic [2:0] ROP_UNUSED_LO = 3'd5;
   localparam logic [2:0] ROP_UNUSED_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Shadow of the frame store and the registers
   logic [15:0] frame_copy [0:STORE_WORDS-1];
   logic [2:0]  cfg_mode;
   logic [4:0]  cfg_weight;
   logic [8:0]  cfg_width;
   logic [8:0]  cfg_height;

   // Read pixels and pixel counts still owed by the block, oldest first
   rsp_type pix_result_q [$];

   int  mismatches     = 0;
   int  results_seen   = 0;
   int  fills_sent     = 0;
   int  reads_sent     = 0;
   int  pixels_painted = 0;
   int  settings_used  = 0;
   bit  gaps_enabled   = 1'b1;

   rgb565_blended_rect_fill u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int active_size(input logic [8:0] raw, input int max_size);
      if (raw == '0) return 1;
      if (int'(raw) > max_size) return max_size;
      return int'(raw);
   endfunction

   // Combine one stored pixel with the fill colour under a raster mode
   function automatic logic [15:0] blend_pixel(input logic [2:0] mode, input logic [15:0] pix,
                                               input logic [15:0] col, input int unsigned wt);
      int unsigned pb, pg, pr, cb, cg, cr, nb, ng, nr;
      logic [15:0] word;
      pb = 32'(pix[4:0]);
      pg = 32'(pix[10:5]);
      pr = 32'(pix[15:11]);
      cb = 32'(col[4:0]);
      cg = 32'(col[10:5]);
      cr = 32'(col[15:11]);
      case (mode)
         ROP_ADD: begin
            nb = (pb + cb > 32'(CHAN5_MAX)) ? 32'(CHAN5_MAX) : pb + cb;
            ng = (pg + cg > 32'(CHAN6_MAX)) ? 32'(CHAN6_MAX) : pg + cg;
            nr = (pr + cr > 32'(CHAN5_MAX)) ? 32'(CHAN5_MAX) : pr + cr;
         end
         ROP_SUB: begin
            nb = (pb > cb) ? pb - cb : 0;
            ng = (pg > cg) ? pg - cg : 0;
            nr = (pr > cr) ? pr - cr : 0;
         end
         default: begin
            nb = (cb * wt + pb * (32'(WEIGHT_FULL) - wt)) >> 4;
            ng = (cg * wt + pg * (32'(WEIGHT_FULL) - wt)) >> 4;
            nr = (cr * wt + pr * (32'(WEIGHT_FULL) - wt)) >> 4;
         end
      endcase
      word = {5'(nr), 6'(ng), 5'(nb)};
      if (mode == ROP_OVERWRITE) word = col;
      else if (mode == ROP_XOR) word = pix ^ col;
      return word;
   endfunction

   // Paint the shadow store for one item and work out the pixel and count it returns
   function automatic rsp_type paint_item(input req_type item);
      rsp_type res;
      int w, h, x0, y0, x1, y1, r, c;
      res = '0;
      if (item.operation == OP_READ) begin
         res.read_pixel = frame_copy[item.pixel_address];
         return res;
      end
      w  = active_size(cfg_width, MAX_WIDTH_DEF);
      h  = active_size(cfg_height, MAX_HEIGHT_DEF);
      x0 = int'(item.left_x);
      y0 = int'(item.top_y);
      x1 = int'(item.right_x);
      y1 = int'(item.bottom_y);
      // Drop meaningless modes, off-screen and inverted boxes, and invisible merges
      if (cfg_mode > ROP_MERGE) return res;
      if (x1 < 0 || x0 > w - 1 || y1 < 0 || y0 > h - 1) return res;
      if (cfg_mode == ROP_MERGE && cfg_weight == '0) return res;
      if (x0 > x1 || y0 > y1) return res;
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > w - 1) x1 = w - 1;
      if (y1 > h - 1) y1 = h - 1;
      for (r = y0; r <= y1; r++) begin
         for (c = x0; c <= x1; c++) begin
            frame_copy[16'(r * w + c)] = blend_pixel(cfg_mode, frame_copy[16'(r * w + c)],
                                                     item.fill_color, 32'(cfg_weight));
         end
      end
      res.pixels_written = 17'((x1 - x0 + 1) * (y1 - y0 + 1));
      return res;
   endfunction

   function automatic req_type make_fill(input int l, input int t, input int r, input int b,
                                         input logic [15:0] col);
      req_type item;
      item.operation     = OP_FILL;
      item.left_x        = 16'(l);
      item.top_y         = 16'(t);
      item.right_x       = 16'(r);
      item.bottom_y      = 16'(b);
      item.fill_color    = col;
      item.pixel_address = 16'($urandom);
      return item;
   endfunction

   function automatic req_type make_read(input logic [15:0] addr);
      req_type item;
      item.operation     = OP_READ;
      item.left_x        = 16'($urandom);
      item.top_y         = 16'($urandom);
      item.right_x       = 16'($urandom);
      item.bottom_y      = 16'($urandom);
      item.fill_color    = 16'($urandom);
      item.pixel_address = addr;
      return item;
   endfunction

   // Hold off new items until every owed result has come back
   task automatic wait_for_results();
      start <= 1'b0;
      while (pix_result_q.size() != 0) @(posedge clock);
   endtask

   // Send one item beat, with an occasional idle burst before it
   task automatic send_item(input req_type item);
      rsp_type owed;
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      owed = paint_item(item);
      pix_result_q.push_back(owed);
      if (item.operation == OP_READ) reads_sent++;
      else begin
         fills_sent++;
         pixels_painted += int'(owed.pixels_written);
      end
   endtask

   // Write all four registers from raw port values once the engine is idle
   task automatic set_config(input logic [8:0] mode_raw, input logic [8:0] weight_raw,
                             input logic [8:0] width_raw, input logic [8:0] height_raw);
      logic [8:0]    vals [4];
      csr_index_type idx;
      vals = '{mode_raw, weight_raw, width_raw, height_raw};
      wait_for_results();
      idx = idx.first();
      repeat (4) begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= vals[idx];
         do @(posedge clock); while (!csr_ready);
         case (idx)
            CSR_RASTER_MODE:   cfg_mode = vals[idx][2:0];
            CSR_MERGE_WEIGHT:  cfg_weight = (vals[idx][4:0] > WEIGHT_FULL) ?
                                            WEIGHT_FULL : vals[idx][4:0];
            CSR_SURFACE_WIDTH: cfg_width = vals[idx];
            default:           cfg_height = vals[idx];
         endcase
         idx = idx.next();
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Reset contents and register defaults: cleared store, overwrite, 240 by 240
   task automatic test_reset_state();
      send_item(make_read(16'h0000));
      send_item(make_read(16'hFFFF));
      send_item(make_fill(238, 238, 300, 300, 16'h1234));
      send_item(make_read(16'(239 * 240 + 239)));
   endtask

   // Widest corners over the largest surface, width write saturating
   task automatic test_full_surface();
      set_config(9'(ROP_OVERWRITE), 9'(WEIGHT_FULL), 9'd511, 9'd256);
      send_item(make_fill(-32768, -32768, 32767, 32767, 16'hF81F));
      send_item(make_read(16'hFFFF));
   endtask

   // Clipping on every edge, rejected boxes, and a zero surface size
   task automatic test_clipping();
      set_config(9'(ROP_OVERWRITE), 9'(WEIGHT_FULL), 9'd0, 9'd0);
      send_item(make_fill(-5, -5, 5, 5, 16'h07E0));
      set_config(9'(ROP_OVERWRITE), 9'(WEIGHT_FULL), 9'd16, 9'd8);
      send_item(make_fill(-3, 2, -1, 4, 16'hAAAA));
      send_item(make_fill(16, 0, 20, 3, 16'hAAAA));
      send_item(make_fill(0, 8, 3, 9, 16'hAAAA));
      send_item(make_fill(-32768, -32768, 32767, -1, 16'hAAAA));
      send_item(make_fill(5, 1, 4, 3, 16'hAAAA));
      send_item(make_fill(14, 6, 40, 40, 16'h5555));
      send_item(make_read(16'(7 * 16 + 15)));
   endtask

   // XOR, add, subtract and merge modes on two pixels with read-backs, then codes past merge
   task automatic test_raster_modes();
      set_config(9'(ROP_XOR), 9'(WEIGHT_FULL), 9'd16, 9'd8);
      send_item(make_fill(2, 0, 3, 0, 16'hFFFF));
      send_item(make_read(16'd2));
      // additive saturates the channels that overflow
      set_config(9'(ROP_ADD), 9'(WEIGHT_FULL), 9'd16, 9'd8);
      send_item(make_fill(2, 0, 3, 0, 16'h8410));
      send_item(make_read(16'd2));
      // subtractive clamps every channel at zero
      set_config(9'(ROP_SUB), 9'(WEIGHT_FULL), 9'd16, 9'd8);
      send_item(make_fill(2, 0, 3, 0, 16'hFFFF));
      send_item(make_read(16'd3));
      // merge with no weight draws nothing
      set_config(9'(ROP_MERGE), 9'd0, 9'd16, 9'd8);
      send_item(make_fill(2, 0, 3, 0, 16'hFFFF));
      // weight write above full saturates
      set_config(9'(ROP_MERGE), 9'h1FF, 9'd16, 9'd8);
      send_item(make_fill(2, 0, 3, 0, 16'h1234));
      send_item(make_read(16'd2));
      set_config(9'(ROP_MERGE), 9'd8, 9'd16, 9'd8);
      send_item(make_fill(2, 0, 3, 0, 16'hFFFF));
      send_item(make_read(16'd3));
      // codes past merge leave the store alone
      set_config(9'(ROP_UNUSED_LO), 9'd8, 9'd16, 9'd8);
      send_item(make_fill(0, 0, 15, 7, 16'hFFFF));
      set_config({6'h3F, ROP_UNUSED_HI}, 9'd8, 9'd16, 9'd8);
      send_item(make_fill(0, 0, 15, 7, 16'hFFFF));
   endtask

   function automatic logic [8:0] pick_size();
      case ($urandom_range(0, 7))
         0:       return 9'($urandom_range(0, 1));
         1:       return 9'($urandom_range(257, 511));
         2:       return 9'd256;
         default: return 9'($urandom_range(1, 48));
      endcase
   endfunction

   // Random phases: random registers, mostly small boxes near the surface
   task automatic test_random_traffic();
      req_type    item;
      logic [2:0] mode3;
      int         w, h, x0, y0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode3 = ($urandom_range(0, 4) == 0) ?
                 3'($urandom_range(ROP_OVERWRITE, ROP_UNUSED_HI)) :
                 3'($urandom_range(ROP_OVERWRITE, ROP_MERGE));
         set_config({6'($urandom), mode3}, {4'($urandom), 5'($urandom)},
                    pick_size(), pick_size());
         gaps_enabled = (phase != RANDOM_PHASES - 1);
         w = active_size(cfg_width, MAX_WIDTH_DEF);
         h = active_size(cfg_height, MAX_HEIGHT_DEF);
         repeat (ITEMS_PER_PHASE) begin
            item = make_fill(int'(16'($urandom)), int'(16'($urandom)),
                             int'(16'($urandom)), int'(16'($urandom)), 16'($urandom));
            if ($urandom_range(0, 9) < 3) begin
               item.operation = OP_READ;
               if ($urandom_range(0, 3) != 0)
                  item.pixel_address = 16'($urandom_range(0, w * h - 1));
            end else if (!(w * h <= 4096 && $urandom_range(0, 9) == 0)) begin
               // keep wide random corners only on small surfaces
               x0 = int'($urandom_range(0, w + 15)) - 8;
               y0 = int'($urandom_range(0, h + 15)) - 8;
               item.left_x   = 16'(x0);
               item.top_y    = 16'(y0);
               item.right_x  = 16'(x0 + int'($urandom_range(0, 14)) - 2);
               item.bottom_y = 16'(y0 + int'($urandom_range(0, 14)) - 2);
            end
            send_item(item);
            if (gaps_enabled && $urandom_range(0, 24) == 0) wait_for_results();
         end
      end
   endtask

   // Check each result beat against the oldest owed one
   always @(posedge clock) begin : check_results
      rsp_type owed;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pix_result_q.size() == 0) begin
            report_mismatch($sformatf("result %0d with none owed: pixel %h count %0d",
                                      results_seen, rsp_data.read_pixel,
                                      rsp_data.pixels_written));
         end else begin
            owed = pix_result_q.pop_front();
            if (rsp_data.read_pixel !== owed.read_pixel)
               report_mismatch($sformatf("result %0d read_pixel %h, want %h", results_seen,
                                         rsp_data.read_pixel, owed.read_pixel));
            if (rsp_data.pixels_written !== owed.pixels_written)
               report_mismatch($sformatf("result %0d pixels_written %0d, want %0d",
                                         results_seen, rsp_data.pixels_written,
                                         owed.pixels_written));
         end
      end
   end

   initial begin
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_RASTER_MODE;
      csr_data  <= '0;
      reset     <= 1'b1;
      foreach (frame_copy[i]) frame_copy[i] = '0;
      cfg_mode   = ROP_OVERWRITE;
      cfg_weight = WEIGHT_FULL;
      cfg_width  = SURFACE_RESET;
      cfg_height = SURFACE_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_full_surface();
      test_clipping();
      test_raster_modes();
      test_random_traffic();

      // Drain, then watch a little longer for stray beats
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d fills painting %0d pixels and %0d reads", fills_sent,
               pixels_painted, reads_sent);
      $display("over %0d register settings, %0d result beats checked", settings_used,
               results_seen);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Give up if the engine stalls
   initial begin
      #(TIMEOUT_CYCLES * 2 * CLOCK_HALF);
      $display("timeout with %0d results still owed", pix_result_q.size());
      $display("simulation failed");
      $finish;
   end

endmodule
